// ----- rtl/advert_payload_parser_assert.svh -----
// Assertion macros for the advert payload parser.
// Needs signals named clk and rst_n in the including module's scope.
`ifndef ADVERT_PAYLOAD_PARSER_ASSERT_SVH
`define ADVERT_PAYLOAD_PARSER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define APP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define APP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/app_pkg.sv -----
// Shared types and constants for the advert payload parser.
// No dependencies.
package app_pkg;

  // Default field sizes
  localparam int KEY_BYTES_DEF  = 32;
  localparam int SIG_BYTES_DEF  = 64;
  localparam int NAME_LIMIT_DEF = 32;

  // Front-to-back queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Flags byte layout
  localparam logic [7:0] FLAG_LATLON = 8'h10;
  localparam logic [7:0] FLAG_EXTRA1 = 8'h20;
  localparam logic [7:0] FLAG_EXTRA2 = 8'h40;
  localparam logic [7:0] FLAG_NAME   = 8'h80;
  localparam logic [7:0] ROLE_MASK   = 8'h0F;

  typedef enum logic [3:0] {
    TAG_KEY   = 4'd0,
    TAG_TIME  = 4'd1,
    TAG_SIG   = 4'd2,
    TAG_FLAGS = 4'd3,
    TAG_LAT   = 4'd4,
    TAG_LON   = 4'd5,
    TAG_EX1   = 4'd6,
    TAG_EX2   = 4'd7,
    TAG_NAME  = 4'd8,
    TAG_IGN   = 4'd9
  } app_tag_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_HDR_SHORT  = 3'd1,
    ST_OPT_TRUNC  = 3'd2,
    ST_NAME_LONG  = 3'd3,
    ST_FRAME_LONG = 3'd4
  } app_status_t;

  // One tagged result beat
  typedef struct packed {
    app_tag_t    field_tag;
    logic [5:0]  field_byte_index;
    logic [7:0]  byte_value;
    logic [3:0]  device_role;
    logic        frame_done;
    app_status_t parse_status;
  } app_item_t;

endpackage

// ----- rtl/app_if.sv -----
// Channel interfaces: raw payload bytes in, tagged results out.
// No dependencies.
interface app_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_last;

  modport source (output valid, output payload_byte, output frame_last, input ready);
  modport sink   (input valid, input payload_byte, input frame_last, output ready);
endinterface

interface app_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] field_tag;
  logic [5:0] field_byte_index;
  logic [7:0] byte_value;
  logic [3:0] device_role;
  logic       frame_done;
  logic [2:0] parse_status;

  modport source (output valid, output field_tag, output field_byte_index,
                  output byte_value, output device_role, output frame_done,
                  output parse_status, input ready);
  modport sink   (input valid, input field_tag, input field_byte_index,
                  input byte_value, input device_role, input frame_done,
                  input parse_status, output ready);
endinterface

// ----- rtl/advert_payload_parser.sv -----
// Advert payload parser: tags each payload byte with its field and index and
// reports a frame status on the last byte. Sustains one byte per clock while the
// queue has room. The rate is set by the front end's per-byte step, an 8-bit
// increment and length compare that picks the next field. A two-beat queue and an
// output register decouple the input from result back-pressure, so input keeps
// flowing while a result waits. Frames longer than 255 bytes end with status
// frame-too-long; after any last byte the parser is ready for a fresh frame.
// Depends on app_pkg, app_if.sv, app_front, app_queue and app_back.
module advert_payload_parser #(
  parameter int KEY_BYTES  = app_pkg::KEY_BYTES_DEF,   // 1..64
  parameter int SIG_BYTES  = app_pkg::SIG_BYTES_DEF,   // 1..64
  parameter int NAME_LIMIT = app_pkg::NAME_LIMIT_DEF   // 1..128
) (
  input  logic      clk,
  input  logic      rst_n,
  app_in_if.sink    in_chan,
  app_out_if.source out_chan
);
  import app_pkg::*;

  // front -> queue
  logic      push_valid;
  logic      push_ready;
  app_item_t push_item;

  // queue -> back
  logic      pop_valid;
  logic      pop_ready;
  app_item_t pop_item;

  // Front: field walk, tagging and end-of-frame checks
  app_front #(
    .KEY_BYTES  (KEY_BYTES),
    .SIG_BYTES  (SIG_BYTES),
    .NAME_LIMIT (NAME_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Decoupling queue
  app_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // Back: registered result beat
  app_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

// ----- rtl/app_front.sv -----
// Front end: accepts payload beats, tracks the field walk, tags and checks.
// Depends on app_pkg, app_if.sv and advert_payload_parser_assert.svh.
module app_front #(
  parameter int KEY_BYTES  = app_pkg::KEY_BYTES_DEF,
  parameter int SIG_BYTES  = app_pkg::SIG_BYTES_DEF,
  parameter int NAME_LIMIT = app_pkg::NAME_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  app_in_if.sink            in_chan,
  output logic              push_valid,
  output app_pkg::app_item_t push_item,
  input  logic              push_ready
);
  import app_pkg::*;

  `include "advert_payload_parser_assert.svh"

  logic [8:0] frame_count_r, frame_count_nxt;
  app_tag_t   cur_field_r, cur_field_nxt;
  logic [7:0] field_offset_r, field_offset_nxt;
  logic [3:0] presence_r, presence_nxt;
  logic [3:0] role_r, role_nxt;

  logic        accept;
  logic        is_flags;
  logic [3:0]  pres_now;
  logic [3:0]  role_now;
  logic [8:0]  count_inc;
  logic [7:0]  offset_inc;
  logic [7:0]  len;
  logic        advance;
  app_tag_t    field_after;
  logic [7:0]  offset_after;
  app_status_t status;

  // Fixed length of a field, zero for unbounded
  function automatic logic [7:0] field_len(app_tag_t f);
    logic [7:0] n;
    case (f)
      TAG_KEY:   n = 8'(KEY_BYTES);
      TAG_TIME:  n = 8'd4;
      TAG_SIG:   n = 8'(SIG_BYTES);
      TAG_FLAGS: n = 8'd1;
      TAG_LAT:   n = 8'd4;
      TAG_LON:   n = 8'd4;
      TAG_EX1:   n = 8'd2;
      TAG_EX2:   n = 8'd2;
      default:   n = 8'd0;
    endcase
    return n;
  endfunction

  // Next field given presence bits (bit 0 lat/lon, 1 extra1, 2 extra2, 3 name)
  function automatic app_tag_t next_field(app_tag_t f, logic [3:0] pres);
    app_tag_t n;
    if (f == TAG_KEY) n = TAG_TIME;
    else if (f == TAG_TIME) n = TAG_SIG;
    else if (f == TAG_SIG) n = TAG_FLAGS;
    else if (f == TAG_LAT) n = TAG_LON;
    else if (f == TAG_FLAGS && pres[0]) n = TAG_LAT;
    else if ((f == TAG_FLAGS || f == TAG_LON) && pres[1]) n = TAG_EX1;
    else if ((f == TAG_FLAGS || f == TAG_LON || f == TAG_EX1) && pres[2]) n = TAG_EX2;
    else if (pres[3]) n = TAG_NAME;
    else n = TAG_IGN;
    return n;
  endfunction

  assign accept         = in_chan.valid && push_ready;
  assign in_chan.ready  = push_ready;
  assign push_valid     = in_chan.valid;

  always_comb begin
    is_flags   = (cur_field_r == TAG_FLAGS);
    pres_now   = is_flags ? in_chan.payload_byte[7:4] : presence_r;
    role_now   = is_flags ? 4'(in_chan.payload_byte & ROLE_MASK) : role_r;
    count_inc  = frame_count_r[8] ? frame_count_r : frame_count_r + 9'd1;
    offset_inc = (&field_offset_r) ? field_offset_r : field_offset_r + 8'd1;
    len        = field_len(cur_field_r);
    advance    = (len != 8'd0) && (offset_inc >= len);
    field_after  = advance ? next_field(cur_field_r, pres_now) : cur_field_r;
    offset_after = advance ? 8'd0 : offset_inc;

    status = ST_OK;
    if (in_chan.frame_last) begin
      if (count_inc[8]) status = ST_FRAME_LONG;
      else if (field_after <= TAG_SIG) status = ST_HDR_SHORT;
      else if (field_after >= TAG_LAT && field_after <= TAG_EX2) status = ST_OPT_TRUNC;
      else if (field_after == TAG_NAME && offset_after > 8'(NAME_LIMIT))
        status = ST_NAME_LONG;
    end

    push_item.field_tag        = cur_field_r;
    push_item.field_byte_index = (field_offset_r > 8'd63) ? 6'd63 : field_offset_r[5:0];
    push_item.byte_value       = in_chan.payload_byte;
    push_item.device_role      = role_now;
    push_item.frame_done       = in_chan.frame_last;
    push_item.parse_status     = status;

    frame_count_nxt  = frame_count_r;
    cur_field_nxt    = cur_field_r;
    field_offset_nxt = field_offset_r;
    presence_nxt     = presence_r;
    role_nxt         = role_r;
    if (accept) begin
      if (in_chan.frame_last) begin
        frame_count_nxt  = '0;
        cur_field_nxt    = TAG_KEY;
        field_offset_nxt = '0;
        presence_nxt     = '0;
        role_nxt         = '0;
      end else begin
        frame_count_nxt  = count_inc;
        cur_field_nxt    = field_after;
        field_offset_nxt = offset_after;
        presence_nxt     = pres_now;
        role_nxt         = role_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= '0;
      cur_field_r    <= TAG_KEY;
      field_offset_r <= '0;
      presence_r     <= '0;
      role_r         <= '0;
    end else begin
      frame_count_r  <= frame_count_nxt;
      cur_field_r    <= cur_field_nxt;
      field_offset_r <= field_offset_nxt;
      presence_r     <= presence_nxt;
      role_r         <= role_nxt;
    end
  end

  `APP_ASSERT_NOW(a_status_only_on_last, accept && !in_chan.frame_last, status == ST_OK, "status on non-final beat")
  `APP_ASSERT_NEXT(a_rearm_after_last, accept && in_chan.frame_last, frame_count_r == 9'd0 && cur_field_r == TAG_KEY && role_r == 4'd0, "parser not rearmed after last beat")

endmodule

// ----- rtl/app_queue.sv -----
// Short FIFO between the classifying front end and the output stage.
// Depends on app_pkg and advert_payload_parser_assert.svh.
module app_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  app_pkg::app_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output app_pkg::app_item_t pop_item,
  input  logic               pop_ready
);
  import app_pkg::*;

  `include "advert_payload_parser_assert.svh"

  app_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  `APP_ASSERT_NOW(a_count_bound, 1'b1, count_r <= Q_CNT_W'(Q_DEPTH), "queue count past depth")
  `APP_ASSERT_NEXT(a_empty_fill, count_r == '0 && do_push, pop_valid && pop_item == $past(push_item), "first beat into empty queue lost")

endmodule

// ----- rtl/app_back.sv -----
// Output stage: registers one result beat and drives the result channel.
// Depends on app_pkg and app_if.sv.
module app_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  app_pkg::app_item_t pop_item,
  output logic               pop_ready,
  app_out_if.source          out_chan
);
  import app_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  app_item_t out_item_r;

  // Refill whenever the holding register is empty or being drained
  assign pop_ready     = !out_valid_r || out_chan.ready;
  assign out_valid_nxt = pop_ready ? pop_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) out_item_r <= pop_item;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.field_tag        = out_item_r.field_tag;
  assign out_chan.field_byte_index = out_item_r.field_byte_index;
  assign out_chan.byte_value       = out_item_r.byte_value;
  assign out_chan.device_role      = out_item_r.device_role;
  assign out_chan.frame_done       = out_item_r.frame_done;
  assign out_chan.parse_status     = out_item_r.parse_status;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for advert_payload_parser: directed frames, then random frames.
// Depends on app_pkg, app_if.sv and the parser RTL.
module testbench;
  import app_pkg::*;

  // Flags byte follows key, timestamp and signature
  localparam int HDR_LEN   = KEY_BYTES_DEF + 4 + SIG_BYTES_DEF;
  localparam int TOTAL_BYTES = 1500;

  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  // One directed frame: length, flags byte, header fill, final status if typed in
  typedef struct {
    int          len;
    logic [7:0]  flags;
    fill_t       fill;
    bit          typed;
    app_status_t status;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  app_in_if  in_chan();
  app_out_if out_chan();

  advert_payload_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #4 clk = ~clk;

  // Tagger state, starts clear and is cleared after every last byte
  logic [8:0] frame_len_seen = '0;
  app_tag_t   cur_field = TAG_KEY;
  logic [7:0] field_pos = '0;
  logic [7:0] opt_flags = '0;
  logic [3:0] role_nib = '0;

  app_item_t tagged_q[$];
  int        fail_count = 0;
  int        bytes_sent = 0;
  bit        out_taken = 1'b0;
  bit        tx_gappy = 1'b1;

  // Directed frames. The status column comes straight from the frame layout.
  frame_row_t plan [10] = '{
    '{1,   8'h00, FILL_ZERO, 1'b1, ST_HDR_SHORT},   // single key byte
    '{99,  8'h00, FILL_ONES, 1'b1, ST_HDR_SHORT},   // one signature byte short
    '{100, 8'h00, FILL_RAND, 1'b1, ST_OK},          // header exactly, no flags byte
    '{101, 8'h10, FILL_RAND, 1'b1, ST_OPT_TRUNC},   // lat/lon flagged, not begun
    '{112, 8'h70, FILL_RAND, 1'b1, ST_OPT_TRUNC},   // extra2 half done
    '{145, 8'hF5, FILL_RAND, 1'b1, ST_OK},          // every option, name at the limit
    '{134, 8'h80, FILL_RAND, 1'b1, ST_NAME_LONG},   // name one over
    '{120, 8'h0A, FILL_ZERO, 1'b1, ST_OK},          // unclaimed tail
    '{258, 8'h90, FILL_RAND, 1'b1, ST_FRAME_LONG},  // count saturates
    '{103, 8'hC3, FILL_RAND, 1'b0, ST_OK}           // predictor only
  };

  function automatic int field_size(app_tag_t f);
    case (f)
      TAG_KEY:           return KEY_BYTES_DEF;
      TAG_SIG:           return SIG_BYTES_DEF;
      TAG_FLAGS:         return 1;
      TAG_TIME, TAG_LAT,
      TAG_LON:           return 4;
      TAG_EX1, TAG_EX2:  return 2;
      default:           return 0;   // name and ignored run to frame end
    endcase
  endfunction

  function automatic app_tag_t field_after(app_tag_t f, logic [7:0] opt);
    case (f)
      TAG_KEY:  return TAG_TIME;
      TAG_TIME: return TAG_SIG;
      TAG_SIG:  return TAG_FLAGS;
      TAG_LAT:  return TAG_LON;
      default: ;
    endcase
    if (f == TAG_FLAGS && (opt & FLAG_LATLON) != 0)
      return TAG_LAT;
    if ((f == TAG_FLAGS || f == TAG_LON) && (opt & FLAG_EXTRA1) != 0)
      return TAG_EX1;
    if ((f == TAG_FLAGS || f == TAG_LON || f == TAG_EX1) && (opt & FLAG_EXTRA2) != 0)
      return TAG_EX2;
    if ((opt & FLAG_NAME) != 0)
      return TAG_NAME;
    return TAG_IGN;
  endfunction

  // Tag one byte and advance the tagger; frame status lands on the last byte
  function automatic app_item_t tag_next_byte(logic [7:0] b, logic is_last);
    app_item_t r;
    int        len;
    r.field_tag        = cur_field;
    r.field_byte_index = (field_pos > 8'd63) ? 6'd63 : field_pos[5:0];
    r.byte_value       = b;
    if (cur_field == TAG_FLAGS) begin
      opt_flags = b & ~ROLE_MASK;
      role_nib  = 4'(b & ROLE_MASK);
    end
    r.device_role = role_nib;
    if (frame_len_seen < 9'd256) frame_len_seen++;
    if (field_pos < 8'd255) field_pos++;
    len = field_size(cur_field);
    if (len != 0 && field_pos >= len) begin
      cur_field = field_after(cur_field, opt_flags);
      field_pos = '0;
    end
    r.frame_done   = is_last;
    r.parse_status = ST_OK;
    if (is_last) begin
      // length check wins over everything else
      if (frame_len_seen > 9'd255)
        r.parse_status = ST_FRAME_LONG;
      else if (cur_field <= TAG_SIG)
        r.parse_status = ST_HDR_SHORT;
      else if (cur_field >= TAG_LAT && cur_field <= TAG_EX2)
        r.parse_status = ST_OPT_TRUNC;
      else if (cur_field == TAG_NAME && field_pos > NAME_LIMIT_DEF)
        r.parse_status = ST_NAME_LONG;
      frame_len_seen = '0;
      cur_field      = TAG_KEY;
      field_pos      = '0;
      opt_flags      = '0;
      role_nib       = '0;
    end
    return r;
  endfunction

  // Called just after a rising edge (or at start); returns on the edge that takes the beat
  task automatic send_beat(input logic [7:0] b, input logic is_last,
                           input bit typed, input app_status_t st);
    int        gap;
    app_item_t want;
    gap = tx_gappy ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.payload_byte <= b;
    in_chan.frame_last   <= is_last;
    do @(posedge clk); while (!in_chan.ready);
    want = tag_next_byte(b, is_last);
    if (is_last && typed) want.parse_status = st;
    tagged_q.push_back(want);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input logic [7:0] flags, input fill_t fill,
                            input bit typed, input app_status_t st);
    logic [7:0] b;
    tx_gappy = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < len; i++) begin
      if (i == HDR_LEN)
        b = flags;
      else if (fill == FILL_ZERO && i < HDR_LEN)
        b = 8'h00;
      else if (fill == FILL_ONES && i < HDR_LEN)
        b = 8'hFF;
      else
        b = 8'($urandom_range(0, 255));
      send_beat(b, i == len - 1, typed, st);
    end
  endtask

  // Drop valid and hold off until every tagged beat is back
  task automatic drain_results;
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (tagged_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [7:0] flags;
    int         opt_len;
    int         name_bytes;
    int         len;
    in_chan.valid        = 1'b0;
    in_chan.payload_byte = 8'h00;
    in_chan.frame_last   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      send_frame(plan[i].len, plan[i].flags, plan[i].fill, plan[i].typed, plan[i].status);

    drain_results();   // full pause with nothing in flight

    // Random frames: mostly well formed, some short, cut or over-long
    while (bytes_sent < TOTAL_BYTES) begin
      flags    = 8'($urandom_range(0, 255));
      opt_len  = ((flags & FLAG_LATLON) != 0 ? 8 : 0) + ((flags & FLAG_EXTRA1) != 0 ? 2 : 0)
               + ((flags & FLAG_EXTRA2) != 0 ? 2 : 0);
      name_bytes = ((flags & FLAG_NAME) != 0) ? $urandom_range(0, NAME_LIMIT_DEF) : 0;
      len      = HDR_LEN + 1 + opt_len + name_bytes;
      if ($urandom_range(0, 3) == 0)
        len += $urandom_range(1, 20);   // unclaimed tail, or name spills over limit
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, HDR_LEN + 1);
        1: len = HDR_LEN + 1 + $urandom_range(0, opt_len);
        2: len = $urandom_range(256, 300);
        default: ;
      endcase
      send_frame(len, flags, FILL_RAND, 1'b0, ST_OK);
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);   // room for any stray beat
    if (fail_count == 0)
      $display("PASS advert_payload_parser");
    else
      $display("FAIL advert_payload_parser");
    $finish;
  end

  // Result side back-pressure: a random stall after each taken beat,
  // with occasional switches to a no-stall stretch
  initial begin
    int  stall_left;
    bit  rx_gappy;
    stall_left     = 0;
    rx_gappy       = 1'b1;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) rx_gappy = ~rx_gappy;
        stall_left = rx_gappy ? $urandom_range(0, 5) : 0;
      end
      out_chan.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Result checker
  always @(posedge clk) begin
    app_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      out_taken = 1'b1;
      if (tagged_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result beat with nothing expected: tag %0d byte %02h",
                   $realtime, out_chan.field_tag, out_chan.byte_value);
      end else begin
        want = tagged_q.pop_front();
        if (out_chan.field_tag        !== want.field_tag        ||
            out_chan.field_byte_index !== want.field_byte_index ||
            out_chan.byte_value       !== want.byte_value       ||
            out_chan.device_role      !== want.device_role      ||
            out_chan.frame_done       !== want.frame_done       ||
            out_chan.parse_status     !== want.parse_status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch tag/idx/byte/role/done/status exp %0d/%0d/%02h/%0h/%0b/%0d got %0d/%0d/%02h/%0h/%0b/%0d",
                     $realtime, want.field_tag, want.field_byte_index, want.byte_value,
                     want.device_role, want.frame_done, want.parse_status,
                     out_chan.field_tag, out_chan.field_byte_index, out_chan.byte_value,
                     out_chan.device_role, out_chan.frame_done, out_chan.parse_status);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("FAIL advert_payload_parser");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/app_pkg.sv
rtl/app_if.sv
rtl/app_front.sv
rtl/app_queue.sv
rtl/app_back.sv
rtl/advert_payload_parser.sv
tb/testbench.sv
